FILE: rtl/qvat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvat_pkg
// Shared types and constants of the quad vertex affine transform unit.
// ----------------------------------------------------------------------------
package qvat_pkg;

	// Default coordinate width and number of fraction bits of the factors.
	localparam int COORD_BITS_DEFAULT = 16;
	localparam int FRAC_BITS_DEFAULT  = 14;

	// Cosine, sine and scale factors are always 16 bits wide.
	localparam int FACTOR_BITS = 16;

	// Number of vertices and the width of the register index.
	localparam int NUM_VERTS   = 4;
	localparam int CFG_IDX_BITS = 3;

	// Corners loaded at reset, vertex one first.
	localparam int RESET_X [NUM_VERTS] = '{100, 250, 250, 100};
	localparam int RESET_Y [NUM_VERTS] = '{100, 100, 250, 250};

	// Command codes.
	typedef enum logic [1:0] {
		KIND_TRANSLATE = 2'd0,
		KIND_ROTATE    = 2'd1,
		KIND_SCALE     = 2'd2,
		KIND_RESTORE   = 2'd3
	} kind_t;

endpackage

FILE: rtl/qvat_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvat_cmd_if
// Command channel: valid, ready and one command word.
// ----------------------------------------------------------------------------
interface qvat_cmd_if #(
	parameter int COORD_BITS = qvat_pkg::COORD_BITS_DEFAULT
) ();
	logic                                   valid;
	logic                                   ready;
	logic [1:0]                             kind;
	logic signed [COORD_BITS-1:0]           shift_x;
	logic signed [COORD_BITS-1:0]           shift_y;
	logic signed [qvat_pkg::FACTOR_BITS-1:0] cos_value;
	logic signed [qvat_pkg::FACTOR_BITS-1:0] sin_value;
	logic [qvat_pkg::FACTOR_BITS-1:0]        scale_x;
	logic [qvat_pkg::FACTOR_BITS-1:0]        scale_y;

	modport source (
		output valid, kind, shift_x, shift_y, cos_value, sin_value, scale_x, scale_y,
		input  ready
	);

	modport sink (
		input  valid, kind, shift_x, shift_y, cos_value, sin_value, scale_x, scale_y,
		output ready
	);
endinterface

FILE: rtl/qvat_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvat_res_if
// Result channel: valid, ready and one word of four vertices plus a flag.
// ----------------------------------------------------------------------------
interface qvat_res_if #(
	parameter int COORD_BITS = qvat_pkg::COORD_BITS_DEFAULT
) ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] out_x1;
	logic signed [COORD_BITS-1:0] out_y1;
	logic signed [COORD_BITS-1:0] out_x2;
	logic signed [COORD_BITS-1:0] out_y2;
	logic signed [COORD_BITS-1:0] out_x3;
	logic signed [COORD_BITS-1:0] out_y3;
	logic signed [COORD_BITS-1:0] out_x4;
	logic signed [COORD_BITS-1:0] out_y4;
	logic                         saturated;

	modport source (
		output valid, out_x1, out_y1, out_x2, out_y2, out_x3, out_y3, out_x4, out_y4,
		       saturated,
		input  ready
	);

	modport sink (
		input  valid, out_x1, out_y1, out_x2, out_y2, out_x3, out_y3, out_x4, out_y4,
		       saturated,
		output ready
	);
endinterface

FILE: rtl/qvat_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvat_cfg_regs
// Register bank holding the initial corners that a restore command reloads.
// ----------------------------------------------------------------------------
module qvat_cfg_regs #(
	parameter int COORD_BITS = qvat_pkg::COORD_BITS_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [qvat_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [COORD_BITS-1:0]               cfg_data,
	output logic signed [COORD_BITS-1:0]        init_x [qvat_pkg::NUM_VERTS],
	output logic signed [COORD_BITS-1:0]        init_y [qvat_pkg::NUM_VERTS]
);
	import qvat_pkg::*;

	logic signed [COORD_BITS-1:0] init_x_q [NUM_VERTS];
	logic signed [COORD_BITS-1:0] init_y_q [NUM_VERTS];

	// Even indexes hold x, odd indexes hold y; the upper bits pick the vertex.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_VERTS; i++) begin
				init_x_q[i] <= COORD_BITS'(RESET_X[i]);
				init_y_q[i] <= COORD_BITS'(RESET_Y[i]);
			end
		end else if (cfg_we) begin
			if (cfg_index[0]) begin
				init_y_q[cfg_index[CFG_IDX_BITS-1:1]] <= $signed(cfg_data);
			end else begin
				init_x_q[cfg_index[CFG_IDX_BITS-1:1]] <= $signed(cfg_data);
			end
		end
	end

	assign init_x = init_x_q;
	assign init_y = init_y_q;

endmodule

FILE: rtl/qvat_vertex.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvat_vertex
// Datapath for one vertex: translate, rotate, scale or restore, then clip.
// ----------------------------------------------------------------------------
module qvat_vertex #(
	parameter int COORD_BITS = qvat_pkg::COORD_BITS_DEFAULT,
	parameter int FRAC_BITS  = qvat_pkg::FRAC_BITS_DEFAULT
) (
	input  qvat_pkg::kind_t                         kind,
	input  logic signed [COORD_BITS-1:0]            corner_x,
	input  logic signed [COORD_BITS-1:0]            corner_y,
	input  logic signed [COORD_BITS-1:0]            pivot_x,
	input  logic signed [COORD_BITS-1:0]            pivot_y,
	input  logic signed [COORD_BITS-1:0]            init_x,
	input  logic signed [COORD_BITS-1:0]            init_y,
	input  logic signed [COORD_BITS-1:0]            shift_x,
	input  logic signed [COORD_BITS-1:0]            shift_y,
	input  logic signed [qvat_pkg::FACTOR_BITS-1:0] cos_value,
	input  logic signed [qvat_pkg::FACTOR_BITS-1:0] sin_value,
	input  logic [qvat_pkg::FACTOR_BITS-1:0]        scale_x,
	input  logic [qvat_pkg::FACTOR_BITS-1:0]        scale_y,
	output logic signed [COORD_BITS-1:0]            new_x,
	output logic signed [COORD_BITS-1:0]            new_y,
	output logic                                    sat
);
	import qvat_pkg::*;

	// Offset, product, combined product and full result widths.
	localparam int DW = COORD_BITS + 1;
	localparam int MW = DW + FACTOR_BITS + 1;
	localparam int PW = MW + 1;
	localparam int W  = PW + 1;

	localparam logic signed [W-1:0] CoordMax = {{(W-COORD_BITS+1){1'b0}},
		{(COORD_BITS-1){1'b1}}};
	localparam logic signed [W-1:0] CoordMin = {{(W-COORD_BITS+1){1'b1}},
		{(COORD_BITS-1){1'b0}}};

	logic signed [DW-1:0]          dx, dy;
	logic signed [FACTOR_BITS:0]   cos_w, sin_w, sx_w, sy_w;
	logic signed [MW-1:0]          dx_c, dy_s, dx_s, dy_c, dx_sx, dy_sy;
	logic signed [PW-1:0]          rot_x_p, rot_y_p, scl_x_p, scl_y_p;
	logic signed [PW-1:0]          rot_x_t, rot_y_t, scl_x_t, scl_y_t;
	logic signed [W-1:0]           full_x, full_y;
	logic                          sat_x, sat_y;

	// Divide by 2^FRAC_BITS, rounding toward zero.
	function automatic logic signed [PW-1:0] trunc_fix(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] bias;
		bias = {{(PW-FRAC_BITS){1'b0}}, {FRAC_BITS{p[PW-1]}}};
		return (p + bias) >>> FRAC_BITS;
	endfunction

	// Offsets from vertex one, and factors widened to one common signed width.
	assign dx    = DW'(corner_x) - DW'(pivot_x);
	assign dy    = DW'(corner_y) - DW'(pivot_y);
	assign cos_w = (FACTOR_BITS+1)'(cos_value);
	assign sin_w = (FACTOR_BITS+1)'(sin_value);
	assign sx_w  = $signed({1'b0, scale_x});
	assign sy_w  = $signed({1'b0, scale_y});

	// One rank of multipliers.
	assign dx_c  = MW'(dx) * MW'(cos_w);
	assign dy_s  = MW'(dy) * MW'(sin_w);
	assign dx_s  = MW'(dx) * MW'(sin_w);
	assign dy_c  = MW'(dy) * MW'(cos_w);
	assign dx_sx = MW'(dx) * MW'(sx_w);
	assign dy_sy = MW'(dy) * MW'(sy_w);

	assign rot_x_p = PW'(dx_c) - PW'(dy_s);
	assign rot_y_p = PW'(dx_s) + PW'(dy_c);
	assign scl_x_p = PW'(dx_sx);
	assign scl_y_p = PW'(dy_sy);

	assign rot_x_t = trunc_fix(rot_x_p);
	assign rot_y_t = trunc_fix(rot_y_p);
	assign scl_x_t = trunc_fix(scl_x_p);
	assign scl_y_t = trunc_fix(scl_y_p);

	// Select the new position at full precision.
	always_comb begin
		case (kind)
			KIND_TRANSLATE: begin
				full_x = W'(corner_x) + W'(shift_x);
				full_y = W'(corner_y) + W'(shift_y);
			end
			KIND_ROTATE: begin
				full_x = W'(pivot_x) + W'(rot_x_t);
				full_y = W'(pivot_y) + W'(rot_y_t);
			end
			KIND_SCALE: begin
				full_x = W'(pivot_x) + W'(scl_x_t);
				full_y = W'(pivot_y) + W'(scl_y_t);
			end
			default: begin
				full_x = W'(init_x);
				full_y = W'(init_y);
			end
		endcase
	end

	// Clip each coordinate to the signed coordinate range.
	always_comb begin
		sat_x = 1'b1;
		sat_y = 1'b1;
		if (full_x > CoordMax) begin
			new_x = CoordMax[COORD_BITS-1:0];
		end else if (full_x < CoordMin) begin
			new_x = CoordMin[COORD_BITS-1:0];
		end else begin
			new_x = full_x[COORD_BITS-1:0];
			sat_x = 1'b0;
		end
		if (full_y > CoordMax) begin
			new_y = CoordMax[COORD_BITS-1:0];
		end else if (full_y < CoordMin) begin
			new_y = CoordMin[COORD_BITS-1:0];
		end else begin
			new_y = full_y[COORD_BITS-1:0];
			sat_y = 1'b0;
		end
	end

	assign sat = sat_x | sat_y;

endmodule

FILE: rtl/quad_vertex_affine_transform_unit.sv
`timescale 1ns / 1ps
// A command word accepted into the input register gives its result word through the
// corner and result registers. Throughput: one command per cycle while the result
// word is free; the corner registers close the loop between commands.
// Reset: corners and initial-corner registers load (100,100) (250,100) (250,250) (100,250);
// no word is pending on either channel.
// ----------------------------------------------------------------------------
// quad_vertex_affine_transform_unit
// Holds four quadrilateral vertices and applies translate, rotate, scale or
// restore commands to all of them, reporting the new corners after each one.
// ----------------------------------------------------------------------------
module quad_vertex_affine_transform_unit #(
	parameter int COORD_BITS = qvat_pkg::COORD_BITS_DEFAULT,
	parameter int FRAC_BITS  = qvat_pkg::FRAC_BITS_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	qvat_cmd_if.sink                          cmd,
	qvat_res_if.source                        res,
	input  logic                              cfg_we,
	input  logic [qvat_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [COORD_BITS-1:0]             cfg_data
);
	import qvat_pkg::*;

	logic signed [COORD_BITS-1:0] init_x [NUM_VERTS];
	logic signed [COORD_BITS-1:0] init_y [NUM_VERTS];

	// Input register.
	logic                          valid_s1;
	kind_t                         kind_s1;
	logic signed [COORD_BITS-1:0]  shift_x_s1, shift_y_s1;
	logic signed [FACTOR_BITS-1:0] cos_s1, sin_s1;
	logic [FACTOR_BITS-1:0]        scale_x_s1, scale_y_s1;

	// Corner state; it doubles as the result register.
	logic signed [COORD_BITS-1:0]  corner_x_q [NUM_VERTS];
	logic signed [COORD_BITS-1:0]  corner_y_q [NUM_VERTS];
	logic                          valid_s2;
	logic                          sat_s2;

	logic signed [COORD_BITS-1:0]  new_x [NUM_VERTS];
	logic signed [COORD_BITS-1:0]  new_y [NUM_VERTS];
	logic [NUM_VERTS-1:0]          vert_sat;
	logic                          advance;

	qvat_cfg_regs #(
		.COORD_BITS (COORD_BITS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.init_x    (init_x),
		.init_y    (init_y)
	);

	// The command in the input register moves on when the result word is free.
	assign advance   = valid_s1 && (!valid_s2 || res.ready);
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			kind_s1    <= kind_t'(cmd.kind);
			shift_x_s1 <= cmd.shift_x;
			shift_y_s1 <= cmd.shift_y;
			cos_s1     <= cmd.cos_value;
			sin_s1     <= cmd.sin_value;
			scale_x_s1 <= cmd.scale_x;
			scale_y_s1 <= cmd.scale_y;
		end
	end

	// One datapath per vertex, all pivoting on vertex one.
	for (genvar v = 0; v < NUM_VERTS; v++) begin : g_vert
		qvat_vertex #(
			.COORD_BITS (COORD_BITS),
			.FRAC_BITS  (FRAC_BITS)
		) u_vert (
			.kind      (kind_s1),
			.corner_x  (corner_x_q[v]),
			.corner_y  (corner_y_q[v]),
			.pivot_x   (corner_x_q[0]),
			.pivot_y   (corner_y_q[0]),
			.init_x    (init_x[v]),
			.init_y    (init_y[v]),
			.shift_x   (shift_x_s1),
			.shift_y   (shift_y_s1),
			.cos_value (cos_s1),
			.sin_value (sin_s1),
			.scale_x   (scale_x_s1),
			.scale_y   (scale_y_s1),
			.new_x     (new_x[v]),
			.new_y     (new_y[v]),
			.sat       (vert_sat[v])
		);
	end

	// Corner update and result word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_VERTS; i++) begin
				corner_x_q[i] <= COORD_BITS'(RESET_X[i]);
				corner_y_q[i] <= COORD_BITS'(RESET_Y[i]);
			end
			valid_s2 <= 1'b0;
			sat_s2   <= 1'b0;
		end else begin
			if (advance) begin
				corner_x_q <= new_x;
				corner_y_q <= new_y;
				sat_s2     <= |vert_sat;
				valid_s2   <= 1'b1;
			end else if (res.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	assign res.valid     = valid_s2;
	assign res.out_x1    = corner_x_q[0];
	assign res.out_y1    = corner_y_q[0];
	assign res.out_x2    = corner_x_q[1];
	assign res.out_y2    = corner_y_q[1];
	assign res.out_x3    = corner_x_q[2];
	assign res.out_y3    = corner_y_q[2];
	assign res.out_x4    = corner_x_q[3];
	assign res.out_y4    = corner_y_q[3];
	assign res.saturated = sat_s2;

endmodule
